// ===== design/tba_pkg.sv =====
// Shared types, constants and helpers for the tile bitmap allocator.
`default_nettype none
package tba_pkg;

   localparam int SLOT_TOTAL = 1024;
   localparam int MAX_RUN    = 128;
   localparam int WORD_W     = 32;
   localparam int MAP_WORDS  = SLOT_TOTAL / WORD_W;
   localparam int HALF_WORDS = MAP_WORDS / 2;

   localparam int WORD_BIT_W = $clog2(WORD_W);
   localparam int MAP_IDX_W  = $clog2(MAP_WORDS);
   localparam int SLOT_W     = MAP_IDX_W + WORD_BIT_W;
   localparam int POS_W      = SLOT_W + 1;
   localparam int EXT_W      = SLOT_W + 2;
   localparam int COUNT_W    = 8;
   localparam int ACTION_W   = 2;

   localparam logic [WORD_W-1:0]    WORD_ONES = '1;
   localparam logic [COUNT_W-1:0]   MAX_RUN_C = COUNT_W'(MAX_RUN);
   localparam logic [POS_W-1:0]     SLOT_END  = POS_W'(SLOT_TOTAL);
   localparam logic [EXT_W-1:0]     SLOT_END_X = EXT_W'(SLOT_TOTAL);
   localparam logic [MAP_IDX_W-1:0] LAST_WORD = MAP_IDX_W'(MAP_WORDS - 1);
   localparam logic [MAP_IDX_W-1:0] HALF_WORD = MAP_IDX_W'(HALF_WORDS);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK_FREE,
      ST_SEEK_USED,
      ST_MARK,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [MAP_IDX_W-1:0] idx;
      logic [WORD_W-1:0]    data;
   } map_wr_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic upper_empty;
   } map_status_type;

   // index of the lowest set bit; zero when none is set
   function automatic logic [WORD_BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
      logic [WORD_BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = WORD_BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// ===== design/tile_bitmap_allocator.sv =====
// Top level of the tile bitmap allocator: request sequencer around the slot map.
//
// Keeps a 1024-slot free map as 32 words of 32 bits and serves one request
// at a time; req_stall is high from the transfer until the result is handed
// to the response register. Allocate walks the map one word per cycle with a
// find-first unit, revisiting the current word at each free-run boundary it
// passes, then marks the run in at most five word writes. Free likewise marks
// its run (clamped to 128 slots and to the map end) in at most five word
// writes, clear writes every word once, and an oversized allocate or an
// unknown request goes straight to the finish state. Status flags are kept
// per word, so full/empty reporting needs no scan of the map. A finished
// result waits in the response register while the next request is taken.
`default_nettype none
module tile_bitmap_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tba_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [tba_pkg::COUNT_W-1:0]   req_slot_count,
   input  wire logic                          req_align_two,
   input  wire logic [tba_pkg::SLOT_W-1:0]    req_start_req,
   input  wire logic                          req_reserve_lower,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_ok,
   output logic [tba_pkg::SLOT_W-1:0]         rsp_run_start,
   output logic                               rsp_full_res,
   output logic                               rsp_empty_res,
   output logic                               rsp_upper_empty
);

   tba_pkg::state_type               state_ff, state_in;
   logic [tba_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [tba_pkg::EXT_W-1:0]        end_ff, end_in;
   logic [tba_pkg::EXT_W-1:0]        seg_ff, seg_in;
   logic [tba_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             align_ff, align_in;
   logic                             reserve_ff, reserve_in;
   logic                             set_ff, set_in;
   logic                             ok_ff, ok_in;
   logic [tba_pkg::SLOT_W-1:0]       where_ff, where_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [tba_pkg::SLOT_W-1:0]       rsp_run_start_ff, rsp_run_start_in;
   logic                             rsp_full_ff, rsp_full_in;
   logic                             rsp_empty_ff, rsp_empty_in;
   logic                             rsp_upper_ff, rsp_upper_in;

   logic [tba_pkg::MAP_IDX_W-1:0]    rd_idx;
   logic [tba_pkg::WORD_W-1:0]       rd_data;
   tba_pkg::map_wr_type              wr;
   tba_pkg::map_status_type          status;

   logic [tba_pkg::WORD_W-1:0]       low_mask;
   logic [tba_pkg::WORD_W-1:0]       free_hits;
   logic [tba_pkg::WORD_W-1:0]       used_hits;
   logic [tba_pkg::WORD_W-1:0]       mark_mask;
   logic [tba_pkg::POS_W-1:0]        word_end;
   logic [tba_pkg::POS_W-1:0]        free_pos;
   logic [tba_pkg::POS_W-1:0]        used_pos;
   logic [tba_pkg::POS_W-1:0]        hit_pos;
   logic [tba_pkg::EXT_W-1:0]        cand_start;
   logic [tba_pkg::EXT_W-1:0]        need_ext;
   logic [tba_pkg::EXT_W-1:0]        free_end;
   logic [tba_pkg::COUNT_W-1:0]      free_count;

   tba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .wr      (wr),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tba_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      end_ff           <= end_in;
      seg_ff           <= seg_in;
      count_ff         <= count_in;
      align_ff         <= align_in;
      reserve_ff       <= reserve_in;
      set_ff           <= set_in;
      ok_ff            <= ok_in;
      where_ff         <= where_in;
      rsp_ok_ff        <= rsp_ok_in;
      rsp_run_start_ff <= rsp_run_start_in;
      rsp_full_ff      <= rsp_full_in;
      rsp_empty_ff     <= rsp_empty_in;
      rsp_upper_ff     <= rsp_upper_in;
   end

   // shared find-first datapath on the word under pos
   assign rd_idx    = pos_ff[tba_pkg::SLOT_W-1:tba_pkg::WORD_BIT_W];
   assign low_mask  = tba_pkg::WORD_ONES << pos_ff[tba_pkg::WORD_BIT_W-1:0];
   assign free_hits = rd_data & low_mask;
   assign used_hits = ~rd_data & low_mask;
   assign word_end  = (tba_pkg::POS_W'(rd_idx) + tba_pkg::POS_W'(1)) << tba_pkg::WORD_BIT_W;
   assign free_pos  = {1'b0, rd_idx, tba_pkg::first_set(free_hits)};
   assign used_pos  = {1'b0, rd_idx, tba_pkg::first_set(used_hits)};
   assign hit_pos   = (|used_hits) ? used_pos : word_end;

   assign cand_start = tba_pkg::EXT_W'(free_pos) + tba_pkg::EXT_W'(align_ff & free_pos[0]);
   assign need_ext   = (count_ff == '0) ? tba_pkg::EXT_W'(1) : tba_pkg::EXT_W'(count_ff);

   assign free_count = (req_slot_count > tba_pkg::MAX_RUN_C) ? tba_pkg::MAX_RUN_C
                                                              : req_slot_count;
   assign free_end   = tba_pkg::EXT_W'(req_start_req) + tba_pkg::EXT_W'(free_count);

   assign mark_mask = (end_ff >= tba_pkg::EXT_W'(word_end)) ? low_mask
      : (low_mask & ~(tba_pkg::WORD_ONES << end_ff[tba_pkg::WORD_BIT_W-1:0]));

   always_comb begin
      state_in         = state_ff;
      pos_in           = pos_ff;
      end_in           = end_ff;
      seg_in           = seg_ff;
      count_in         = count_ff;
      align_in         = align_ff;
      reserve_in       = reserve_ff;
      set_in           = set_ff;
      ok_in            = ok_ff;
      where_in         = where_ff;
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_ok_in        = rsp_ok_ff;
      rsp_run_start_in = rsp_run_start_ff;
      rsp_full_in      = rsp_full_ff;
      rsp_empty_in     = rsp_empty_ff;
      rsp_upper_in     = rsp_upper_ff;
      wr.en            = 1'b0;
      wr.idx           = rd_idx;
      wr.data          = rd_data;

      unique case (state_ff)
         tba_pkg::ST_IDLE: begin
            if (req_valid) begin
               count_in   = req_slot_count;
               align_in   = req_align_two;
               reserve_in = req_reserve_lower;
               ok_in      = 1'b0;
               where_in   = '0;
               unique case (req_action)
                  tba_pkg::ACT_ALLOC: begin
                     if (req_slot_count > tba_pkg::MAX_RUN_C) begin
                        state_in = tba_pkg::ST_FINISH;
                     end else begin
                        pos_in   = '0;
                        state_in = tba_pkg::ST_SEEK_FREE;
                     end
                  end
                  tba_pkg::ACT_FREE: begin
                     ok_in    = 1'b1;
                     set_in   = 1'b1;
                     pos_in   = tba_pkg::POS_W'(req_start_req);
                     end_in   = (free_end > tba_pkg::SLOT_END_X) ? tba_pkg::SLOT_END_X
                                                                 : free_end;
                     state_in = tba_pkg::ST_MARK;
                  end
                  tba_pkg::ACT_CLEAR: begin
                     ok_in    = 1'b1;
                     pos_in   = '0;
                     state_in = tba_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = tba_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         tba_pkg::ST_SEEK_FREE: begin
            if (|free_hits) begin
               seg_in   = cand_start;
               end_in   = cand_start + need_ext;
               pos_in   = free_pos;
               state_in = tba_pkg::ST_SEEK_USED;
            end else if (word_end >= tba_pkg::SLOT_END) begin
               state_in = tba_pkg::ST_FINISH;
            end else begin
               pos_in = word_end;
            end
         end

         tba_pkg::ST_SEEK_USED: begin
            if (tba_pkg::EXT_W'(hit_pos) >= end_ff) begin
               ok_in    = 1'b1;
               where_in = seg_ff[tba_pkg::SLOT_W-1:0];
               set_in   = 1'b0;
               pos_in   = seg_ff[tba_pkg::POS_W-1:0];
               end_in   = seg_ff + tba_pkg::EXT_W'(count_ff);
               state_in = tba_pkg::ST_MARK;
            end else if (|used_hits) begin
               pos_in   = used_pos;
               state_in = tba_pkg::ST_SEEK_FREE;
            end else if (word_end >= tba_pkg::SLOT_END) begin
               state_in = tba_pkg::ST_FINISH;
            end else begin
               pos_in = word_end;
            end
         end

         tba_pkg::ST_MARK: begin
            if (tba_pkg::EXT_W'(pos_ff) >= end_ff) begin
               state_in = tba_pkg::ST_FINISH;
            end else begin
               wr.en   = 1'b1;
               wr.data = set_ff ? (rd_data | mark_mask) : (rd_data & ~mark_mask);
               pos_in  = (end_ff >= tba_pkg::EXT_W'(word_end)) ? word_end
                                                               : end_ff[tba_pkg::POS_W-1:0];
            end
         end

         tba_pkg::ST_CLEAR: begin
            wr.en   = 1'b1;
            wr.data = (reserve_ff && (rd_idx < tba_pkg::HALF_WORD)) ? '0 : tba_pkg::WORD_ONES;
            if (rd_idx == tba_pkg::LAST_WORD) begin
               state_in = tba_pkg::ST_FINISH;
            end else begin
               pos_in = word_end;
            end
         end

         tba_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_ok_in        = ok_ff;
               rsp_run_start_in = where_ff;
               rsp_full_in      = status.full;
               rsp_empty_in     = status.empty;
               rsp_upper_in     = status.upper_empty;
               state_in         = tba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tba_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall       = (state_ff != tba_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_run_start   = rsp_run_start_ff;
   assign rsp_full_res    = rsp_full_ff;
   assign rsp_empty_res   = rsp_empty_ff;
   assign rsp_upper_empty = rsp_upper_ff;

endmodule
`default_nettype wire

// ===== design/tba_map.sv =====
// Slot availability map: one word read and one word write per cycle, with per-word status flags.
`default_nettype none
module tba_map (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tba_pkg::MAP_IDX_W-1:0]  rd_idx,
   output logic [tba_pkg::WORD_W-1:0]          rd_data,
   input  wire tba_pkg::map_wr_type            wr,
   output tba_pkg::map_status_type             status
);

   logic [tba_pkg::WORD_W-1:0]    word_ff [tba_pkg::MAP_WORDS];
   logic [tba_pkg::MAP_WORDS-1:0] all_free_ff;
   logic [tba_pkg::MAP_WORDS-1:0] all_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < tba_pkg::MAP_WORDS; w++) begin
            word_ff[w] <= tba_pkg::WORD_ONES;
         end
         all_free_ff <= '1;
         all_used_ff <= '0;
      end else if (wr.en) begin
         word_ff[wr.idx]     <= wr.data;
         all_free_ff[wr.idx] <= &wr.data;
         all_used_ff[wr.idx] <= ~|wr.data;
      end
   end

   assign rd_data            = word_ff[rd_idx];
   assign status.full        = &all_used_ff;
   assign status.empty       = &all_free_ff;
   assign status.upper_empty = &all_free_ff[tba_pkg::MAP_WORDS-1:tba_pkg::HALF_WORDS];

endmodule
`default_nettype wire
